[hw/rtl/tcw_pkg.sv]
// Shared types, constants and address helpers for the text console writer.
package tcw_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = ROWS * COLUMNS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;

    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_SCROLL = ADDR_W'(SCROLL_CELLS - 1);
    localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'(SCROLL_CELLS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

    // Operation codes.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Control characters and the blank.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] target_row;
        logic [COL_W-1:0] target_col;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0]  row_now;
        logic [COL_W-1:0]  col_now;
        logic [ADDR_W-1:0] cursor_linear;
        logic [CELL_W-1:0] cell_word;
    } t_result;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ROW_STRIDE) + ADDR_W'(col);
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] row);
        return (row > LAST_ROW) ? LAST_ROW : row;
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] col);
        return (col > LAST_COL) ? LAST_COL : col;
    endfunction

endpackage

[hw/rtl/text_console_writer.sv]
// Top level of the text console writer: cursor control and cell store sequencer.
//
// A command word is taken on i_cmd when start is high and busy is low. Every
// command gives exactly one result word on o_result, shown for one cycle with
// o_strobe high; the receiver cannot stall it. The attribute byte used for
// written and blanked cells comes in on the config channel (i_cfg_valid with
// o_cfg_ready, always ready) and should change only while the block is idle.
// Put (when it does not scroll), carriage return, backspace and set cursor are done
// in the accept cycle and register their result; busy stays low, so they can follow
// each other back to back. A read cell waits for one registered read of the cell
// memory. A clear writes one cell per cycle. A newline or line wrap on the last row
// scrolls: it moves one cell per cycle through the memory's single read and single
// write port, then blanks the bottom line. The single write port of the cell memory
// sets the pace of clear and scroll. Busy is high while a longer command is in
// progress and is low again when its strobe is shown.
// After reset the memory is swept to blanks in color 7 with busy high; config
// writes are taken during the sweep.
module text_console_writer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tcw_pkg::t_cmd  i_cmd,
    output logic           o_strobe,
    output tcw_pkg::t_result o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);
    import tcw_pkg::*;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CLEAR  = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_READ   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_waddr, n_waddr;
    logic [7:0]        r_color;
    logic              r_strobe, n_strobe;
    t_result           r_result;
    logic [CELL_W-1:0] n_word;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic              accept;
    logic              do_newline;
    logic [ROW_W-1:0]  tgt_row;
    logic [COL_W-1:0]  tgt_col;

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign tgt_row     = clamp_row(i_cmd.target_row);
    assign tgt_col     = clamp_col(i_cmd.target_col);

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_waddr    = r_waddr;
        n_strobe   = 1'b0;
        n_word     = '0;
        do_newline = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = {r_color, CH_BLANK};
        mem_raddr  = r_idx;

        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_COLOR, CH_BLANK};
                if (r_idx == LAST_CELL) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.op)
                        OP_PUT: begin
                            if (i_cmd.char_code == CH_NEWLINE) begin
                                do_newline = 1'b1;
                            end else if (i_cmd.char_code == CH_RETURN) begin
                                n_col    = '0;
                                n_strobe = 1'b1;
                            end else if (i_cmd.char_code == CH_BACKSPACE) begin
                                if (r_col != '0) begin
                                    n_col     = r_col - 1'b1;
                                    mem_we    = 1'b1;
                                    mem_waddr = cell_addr(r_row, r_col - 1'b1);
                                end
                                n_strobe = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(r_row, r_col);
                                mem_wdata = {r_color, i_cmd.char_code};
                                if (r_col == LAST_COL) begin
                                    do_newline = 1'b1;
                                end else begin
                                    n_col    = r_col + 1'b1;
                                    n_strobe = 1'b1;
                                end
                            end
                        end
                        OP_SET: begin
                            n_row    = tgt_row;
                            n_col    = tgt_col;
                            n_strobe = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_READ: begin
                            mem_raddr = cell_addr(tgt_row, tgt_col);
                            n_state   = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase

                    if (do_newline) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            n_idx   = '0;
                            n_state = S_SCROLL;
                        end else begin
                            n_row    = r_row + 1'b1;
                            n_strobe = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_word   = mem_rdata;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == LAST_CELL) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCROLL: begin
                // Reads run one row ahead of writes, so a cell is always read
                // before its row is overwritten.
                mem_raddr = r_idx + ROW_STRIDE;
                n_pend    = 1'b1;
                n_waddr   = r_idx;
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_waddr;
                    mem_wdata = mem_rdata;
                end
                if (r_idx == LAST_SCROLL) begin
                    n_idx   = FILL_START;
                    n_state = S_FILL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (r_pend) begin
                    // Last moved word still owns the write port.
                    mem_waddr = r_waddr;
                    mem_wdata = mem_rdata;
                end else if (r_idx == LAST_CELL) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_row    <= '0;
            r_col    <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_color  <= RESET_COLOR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        if (n_strobe) begin
            r_result.row_now       <= n_row;
            r_result.col_now       <= n_col;
            r_result.cursor_linear <= cell_addr(n_row, n_col);
            r_result.cell_word     <= n_word;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_no_result_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_INIT) |-> !o_strobe)
        else $error("result word issued by the reset sweep");

    a_read_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.op == OP_READ) |=> (r_state == S_READ && !o_strobe))
        else $error("read command did not wait for memory data");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.row_now <= LAST_ROW && o_result.col_now <= LAST_COL))
        else $error("cursor out of range in result");

    a_linear_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.cursor_linear ==
                      cell_addr(o_result.row_now, o_result.col_now)))
        else $error("linear cursor does not match row and column");

    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_pend) |-> (r_waddr < mem_raddr))
        else $error("scroll write overtook its read");

endmodule

[hw/rtl/tcw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the text console writer: driver, monitor and screen model.
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    start       = 1'b0;
    t_cmd    i_cmd       = '0;
    logic    i_cfg_valid = 1'b0;
    logic    [7:0] i_cfg_data = 8'h00;
    logic    busy;
    logic    o_strobe;
    t_result o_result;
    logic    o_cfg_ready;

    text_console_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the screen, cursor and attribute byte.
    logic [CELL_W-1:0] shadow_cells [CELLS];
    logic [ROW_W-1:0]  shadow_row;
    logic [COL_W-1:0]  shadow_col;
    logic [7:0]        shadow_color;

    t_cmd    cmd_backlog [$];
    t_result due_reports [$];

    int gap_ceiling = 8;
    int idle_left   = 0;
    int pause       = 0;
    int error_count = 0;
    int cmds_taken  = 0;
    int reports_checked = 0;
    int scroll_count = 0;
    int clear_count  = 0;
    int colors_used  = 0;

    function automatic int cell_at(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        return int'(row) * COLUMNS + int'(col);
    endfunction

    function automatic void blank_range(input int from, input int upto);
        for (int i = from; i < upto; i++)
            shadow_cells[i] = {shadow_color, CH_BLANK};
    endfunction

    // On the last row the whole screen moves up one line instead.
    function automatic void next_line();
        shadow_col = '0;
        if (shadow_row == LAST_ROW) begin
            for (int i = 0; i < SCROLL_CELLS; i++)
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            blank_range(SCROLL_CELLS, CELLS);
            scroll_count++;
        end else begin
            shadow_row = shadow_row + 1'b1;
        end
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        if (ch == CH_NEWLINE) begin
            next_line();
        end else if (ch == CH_RETURN) begin
            shadow_col = '0;
        end else if (ch == CH_BACKSPACE) begin
            if (shadow_col != '0) begin
                shadow_col = shadow_col - 1'b1;
                shadow_cells[cell_at(shadow_row, shadow_col)] = {shadow_color, CH_BLANK};
            end
        end else begin
            shadow_cells[cell_at(shadow_row, shadow_col)] = {shadow_color, ch};
            if (shadow_col == LAST_COL)
                next_line();
            else
                shadow_col = shadow_col + 1'b1;
        end
    endfunction

    function automatic t_result console_step(input t_cmd c);
        t_result          r;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        r   = '0;
        row = (c.target_row > LAST_ROW) ? LAST_ROW : c.target_row;
        col = (c.target_col > LAST_COL) ? LAST_COL : c.target_col;
        case (c.op)
            OP_PUT: begin
                put_char(c.char_code);
            end
            OP_SET: begin
                shadow_row = row;
                shadow_col = col;
            end
            OP_CLEAR: begin
                blank_range(0, CELLS);
                shadow_row = '0;
                shadow_col = '0;
                clear_count++;
            end
            default: begin
                r.cell_word = shadow_cells[cell_at(row, col)];
            end
        endcase
        r.row_now       = shadow_row;
        r.col_now       = shadow_col;
        r.cursor_linear = ADDR_W'(cell_at(shadow_row, shadow_col));
        return r;
    endfunction

    // Driver: holds start high until the word is taken, then waits a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else if (start && !busy) begin
            due_reports.push_back(console_step(i_cmd));
            cmds_taken++;
            pause = $urandom_range(0, gap_ceiling);
            if (pause == 0 && cmd_backlog.size() > 0) begin
                i_cmd <= cmd_backlog.pop_front();
            end else begin
                start     <= 1'b0;
                idle_left <= pause - 1;
            end
        end else if (!start) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
            end else if (cmd_backlog.size() > 0) begin
                i_cmd <= cmd_backlog.pop_front();
                start <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            error_count++;
            if (error_count <= 60)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: every strobed word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_reports.size() == 0) begin
                error_count++;
                if (error_count <= 60)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_result);
            end else begin
                t_result want;
                want = due_reports.pop_front();
                check_field("row_now", 32'(want.row_now), 32'(o_result.row_now));
                check_field("col_now", 32'(want.col_now), 32'(o_result.col_now));
                check_field("cursor_linear", 32'(want.cursor_linear),
                            32'(o_result.cursor_linear));
                check_field("cell_word", 32'(want.cell_word), 32'(o_result.cell_word));
                reports_checked++;
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input logic [7:0] ch,
                             input bit [31:0] row, input bit [31:0] col);
        t_cmd c;
        c.op         = op;
        c.char_code  = ch;
        c.target_row = row[ROW_W-1:0];
        c.target_col = col[COL_W-1:0];
        cmd_backlog.push_back(c);
    endtask

    task automatic write_color(input logic [7:0] color);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= color;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        shadow_color = color;
        colors_used++;
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() > 0 || start || due_reports.size() > 0)
            @(posedge i_clk);
    endtask

    // Positions stay mostly on screen, the rest spans the whole field.
    function automatic int pick_row();
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, ROWS - 1);
        return $urandom_range(0, 31);
    endfunction

    function automatic int pick_col();
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, COLUMNS - 1);
        return $urandom_range(0, 127);
    endfunction

    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 8'($urandom_range(8'h21, 8'h7E));
        if (roll < 80) return 8'($urandom_range(0, 255));
        if (roll < 88) return CH_NEWLINE;
        if (roll < 92) return CH_RETURN;
        return CH_BACKSPACE;
    endfunction

    // Mostly short lines of text at a fresh cursor and runs of cell reads.
    task automatic queue_random(input int quota);
        int made;
        int kind;
        int len;
        made = 0;
        while (made < quota) begin
            kind = $urandom_range(0, 99);
            if (kind < 2) begin
                queue_cmd(OP_CLEAR, 8'($urandom), $urandom, $urandom);
                made++;
            end else if (kind < 12) begin
                queue_cmd(2'($urandom), 8'($urandom), $urandom, $urandom);
                made++;
            end else if (kind < 35) begin
                len = $urandom_range(2, 8);
                repeat (len) queue_cmd(OP_READ, 8'($urandom), pick_row(), pick_col());
                made += len;
            end else begin
                queue_cmd(OP_SET, 8'($urandom), pick_row(), pick_col());
                len = $urandom_range(3, 30);
                repeat (len) queue_cmd(OP_PUT, pick_char(), $urandom, $urandom);
                made += len + 1;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = {RESET_COLOR, CH_BLANK};
        shadow_row   = '0;
        shadow_col   = '0;
        shadow_color = RESET_COLOR;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // The store is swept to blanks after reset while busy is high.
        while (busy) @(posedge i_clk);

        write_color(8'h1E);
        queue_cmd(OP_READ, 0, 0, 0);
        queue_cmd(OP_PUT, 8'h00, 0, 0);
        queue_cmd(OP_PUT, 8'hFF, 31, 127);
        queue_cmd(OP_PUT, "A", 0, 0);
        queue_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
        queue_cmd(OP_PUT, CH_RETURN, 0, 0);
        queue_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
        queue_cmd(OP_PUT, CH_NEWLINE, 0, 0);
        queue_cmd(OP_SET, 0, 31, 127);
        queue_cmd(OP_READ, 0, 31, 127);
        queue_cmd(OP_PUT, "Z", 0, 0);
        queue_cmd(OP_READ, 0, 23, 79);
        queue_cmd(OP_SET, 0, 24, 0);
        queue_cmd(OP_PUT, CH_NEWLINE, 0, 0);
        queue_cmd(OP_READ, 0, 24, 0);
        queue_cmd(OP_SET, 0, 0, 79);
        queue_cmd(OP_PUT, "x", 0, 0);
        queue_cmd(OP_READ, 0, 0, 79);
        queue_cmd(OP_CLEAR, 0, 0, 0);
        queue_cmd(OP_READ, 0, 12, 40);
        queue_cmd(OP_SET, 0, 24, 79);
        queue_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
        queue_cmd(OP_READ, 0, 24, 78);
        queue_cmd(OP_SET, 0, 0, 0);
        wait_drained();

        // Each phase runs under its own attribute byte; one phase never idles.
        for (int phase = 0; phase < 5; phase++) begin
            repeat (4) @(posedge i_clk);
            case (phase)
                0: write_color(8'h00);
                1: write_color(8'hFF);
                3: write_color(RESET_COLOR);
                default: write_color(8'($urandom_range(0, 255)));
            endcase
            gap_ceiling = (phase == 2) ? 0 : 8;
            queue_random(285);
            wait_drained();
        end

        repeat (2100) @(posedge i_clk);
        $display("Ran %0d commands under %0d text colors, with %0d scrolls and %0d clears.",
                 cmds_taken, colors_used, scroll_count, clear_count);
        $display("Checked %0d result words field by field.", reports_checked);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d results still outstanding.", due_reports.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
